>>> hdl/psdl_pkg.sv
// shared types and constants of the priority sorted draw list
`default_nettype none

package psdl_pkg;

    localparam int KEY_W = 16;
    localparam int ID_W  = 8;

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_REMOVE = 2'd1,
        MODE_UPDATE = 2'd2,
        MODE_LIST   = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_FULL      = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_DUP       = 3'd3,
        ST_EMPTY     = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CMP,
        S_EXEC,
        S_LIST
    } t_state;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_INSERT,
        OP_REMOVE,
        OP_ROTATE
    } t_cell_op;

    // broadcast to every cell
    typedef struct packed {
        logic                    cmp;
        t_cell_op                op;
        logic signed [KEY_W-1:0] key;
        logic [ID_W-1:0]         id;
    } t_cell_ctl;

    // what one cell shows its neighbors
    typedef struct packed {
        logic                    valid;
        logic                    gt;
        logic                    pre;
        logic signed [KEY_W-1:0] key;
        logic [ID_W-1:0]         id;
        logic signed [KEY_W-1:0] selk;
    } t_link;

    // seen by the first cell on its left side
    localparam t_link LINK_LEFT_END = '{
        valid: 1'b1, gt: 1'b1, pre: 1'b0, key: '0, id: '0, selk: '0
    };

    // seen by the last cell on its right side
    localparam t_link LINK_RIGHT_END = '{
        valid: 1'b0, gt: 1'b0, pre: 1'b0, key: '0, id: '0, selk: '0
    };

endpackage

`default_nettype wire

>>> hdl/psdl_cell.sv
// one slot of the sorted chain: holds an entry and shifts with its neighbors
`default_nettype none

module psdl_cell (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire psdl_pkg::t_cell_ctl i_ctl,
    input  wire psdl_pkg::t_link     i_left,
    input  wire psdl_pkg::t_link     i_right,
    input  wire psdl_pkg::t_link     i_head,
    output psdl_pkg::t_link          o_link
);

    logic                              r_valid;
    logic                              r_gt;
    logic                              r_match;
    logic signed [psdl_pkg::KEY_W-1:0] r_key;
    logic [psdl_pkg::ID_W-1:0]         r_id;
    logic                              w_pre;

    assign w_pre = i_left.pre | r_match;

    always_comb begin
        o_link.valid = r_valid;
        o_link.gt    = r_gt;
        o_link.pre   = w_pre;
        o_link.key   = r_key;
        o_link.id    = r_id;
        o_link.selk  = i_left.selk | (r_match ? r_key : '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_gt    <= 1'b0;
            r_match <= 1'b0;
        end else begin
            if (i_ctl.cmp) begin
                r_gt    <= r_valid && (i_ctl.key > r_key);
                r_match <= r_valid && (r_id == i_ctl.id);
            end
            case (i_ctl.op)
                psdl_pkg::OP_INSERT: r_valid <= i_left.valid;
                psdl_pkg::OP_REMOVE: r_valid <= i_right.valid;
                default:             r_valid <= r_valid;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_ctl.op)
            psdl_pkg::OP_INSERT: begin
                if (!r_gt) begin
                    // first slot whose key is not below the new one takes it
                    if (i_left.gt) begin
                        r_key <= i_ctl.key;
                        r_id  <= i_ctl.id;
                    end else begin
                        r_key <= i_left.key;
                        r_id  <= i_left.id;
                    end
                end
            end
            psdl_pkg::OP_REMOVE: begin
                if (w_pre) begin
                    r_key <= i_right.key;
                    r_id  <= i_right.id;
                end
            end
            psdl_pkg::OP_ROTATE: begin
                // head entry wraps around to the last held slot
                if (i_right.valid) begin
                    r_key <= i_right.key;
                    r_id  <= i_right.id;
                end else begin
                    r_key <= i_head.key;
                    r_id  <= i_head.id;
                end
            end
            default: begin
                r_key <= r_key;
                r_id  <= r_id;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> hdl/priority_sorted_draw_list.sv
// top level: request sequencer, output register and the chain of slots
// insert and remove: accepted beat, then compare state, then execute state, which waits for a free output
//   register before the result beat; update with a new key: remove pass, then insert pass over the chain
// list: after the execute state, one beat per entry each cycle
//   the sink is ready, the chain rotating once per beat; one request is in work at a time
// reset empties the table (count and slot valid bits); keys and ids are not cleared
`default_nettype none

module priority_sorted_draw_list #(
    parameter int CAPACITY = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire  [23:0] i_s_tdata,   // entry_id[7:0], priority_req[23:8]
    input  wire  [1:0]  i_s_tuser,   // mode[1:0]
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [23:0] o_m_tdata,   // out_id[7:0], out_priority[23:8]
    output logic [2:0]  o_m_tuser,   // status[2:0]
    output logic        o_m_tlast
);

    localparam int CW = $clog2(CAPACITY + 1);

    psdl_pkg::t_state                  r_state, n_state;
    psdl_pkg::t_mode                   r_mode, n_mode;
    logic [psdl_pkg::ID_W-1:0]         r_id;
    logic signed [psdl_pkg::KEY_W-1:0] r_key;
    logic [CW-1:0]                     r_count, n_count;
    logic [CW-1:0]                     r_rem, n_rem;

    logic                              r_out_valid;
    logic [psdl_pkg::ID_W-1:0]         r_out_id;
    logic signed [psdl_pkg::KEY_W-1:0] r_out_key;
    psdl_pkg::t_status                 r_out_status;
    logic                              r_out_last;

    logic                              w_load;
    logic [psdl_pkg::ID_W-1:0]         w_ld_id;
    logic signed [psdl_pkg::KEY_W-1:0] w_ld_key;
    psdl_pkg::t_status                 w_ld_status;
    logic                              w_ld_last;
    logic                              w_out_free;
    logic                              w_accept;

    psdl_pkg::t_cell_ctl               w_ctl;
    psdl_pkg::t_link                   w_link [CAPACITY];
    logic [CAPACITY-1:0]               w_valid_vec;

    logic                              w_found;
    logic                              w_full;
    logic                              w_empty;
    logic signed [psdl_pkg::KEY_W-1:0] w_selk;

    // chain of slots
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        psdl_pkg::t_link w_left;
        psdl_pkg::t_link w_right;
        if (g == 0) begin : g_first
            assign w_left = psdl_pkg::LINK_LEFT_END;
        end else begin : g_mid_l
            assign w_left = w_link[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign w_right = psdl_pkg::LINK_RIGHT_END;
        end else begin : g_mid_r
            assign w_right = w_link[g+1];
        end
        psdl_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_left  (w_left),
            .i_right (w_right),
            .i_head  (w_link[0]),
            .o_link  (w_link[g])
        );
        assign w_valid_vec[g] = w_link[g].valid;
    end

    assign w_found = w_link[CAPACITY-1].pre;
    assign w_full  = w_link[CAPACITY-1].valid;
    assign w_empty = !w_link[0].valid;
    assign w_selk  = w_link[CAPACITY-1].selk;

    assign o_s_tready = (r_state == psdl_pkg::S_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_out_free = !r_out_valid || i_m_tready;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_key, r_out_id};
    assign o_m_tuser  = r_out_status;
    assign o_m_tlast  = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= psdl_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_count     = r_count;
        n_rem       = r_rem;
        w_ctl.cmp   = 1'b0;
        w_ctl.op    = psdl_pkg::OP_NONE;
        w_ctl.key   = r_key;
        w_ctl.id    = r_id;
        w_load      = 1'b0;
        w_ld_id     = r_id;
        w_ld_key    = '0;
        w_ld_status = psdl_pkg::ST_OK;
        w_ld_last   = 1'b1;
        unique case (r_state)
            psdl_pkg::S_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = psdl_pkg::S_CMP;
                end
            end
            psdl_pkg::S_CMP: begin
                w_ctl.cmp = 1'b1;
                n_state   = psdl_pkg::S_EXEC;
            end
            psdl_pkg::S_EXEC: begin
                if (w_out_free) begin
                    n_state = psdl_pkg::S_IDLE;
                    unique case (r_mode)
                        psdl_pkg::MODE_INSERT: begin
                            w_load = 1'b1;
                            if (w_found) begin
                                w_ld_status = psdl_pkg::ST_DUP;
                            end else if (w_full) begin
                                w_ld_status = psdl_pkg::ST_FULL;
                            end else begin
                                w_ctl.op = psdl_pkg::OP_INSERT;
                                w_ld_key = r_key;
                                n_count  = r_count + CW'(1);
                            end
                        end
                        psdl_pkg::MODE_REMOVE: begin
                            w_load = 1'b1;
                            if (!w_found) begin
                                w_ld_status = psdl_pkg::ST_NOT_FOUND;
                            end else begin
                                w_ctl.op = psdl_pkg::OP_REMOVE;
                                w_ld_key = w_selk;
                                n_count  = r_count - CW'(1);
                            end
                        end
                        psdl_pkg::MODE_UPDATE: begin
                            if (!w_found) begin
                                w_load      = 1'b1;
                                w_ld_status = psdl_pkg::ST_NOT_FOUND;
                            end else if (w_selk == r_key) begin
                                w_load   = 1'b1;
                                w_ld_key = r_key;
                            end else begin
                                // take it out, then run an insert pass with the new key
                                w_ctl.op = psdl_pkg::OP_REMOVE;
                                n_count  = r_count - CW'(1);
                                n_mode   = psdl_pkg::MODE_INSERT;
                                n_state  = psdl_pkg::S_CMP;
                            end
                        end
                        psdl_pkg::MODE_LIST: begin
                            if (w_empty) begin
                                w_load      = 1'b1;
                                w_ld_id     = '0;
                                w_ld_status = psdl_pkg::ST_EMPTY;
                            end else begin
                                n_rem   = r_count;
                                n_state = psdl_pkg::S_LIST;
                            end
                        end
                    endcase
                end
            end
            psdl_pkg::S_LIST: begin
                if (w_out_free) begin
                    w_load    = 1'b1;
                    w_ld_id   = w_link[0].id;
                    w_ld_key  = w_link[0].key;
                    w_ld_last = (r_rem == CW'(1));
                    w_ctl.op  = psdl_pkg::OP_ROTATE;
                    n_rem     = r_rem - CW'(1);
                    if (r_rem == CW'(1)) begin
                        n_state = psdl_pkg::S_IDLE;
                    end
                end
            end
            default: begin
                n_state = psdl_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_rem       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            r_rem   <= n_rem;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mode <= psdl_pkg::t_mode'(i_s_tuser);
            r_id   <= i_s_tdata[7:0];
            r_key  <= i_s_tdata[23:8];
        end else begin
            r_mode <= n_mode;
        end
        if (w_load) begin
            r_out_id     <= w_ld_id;
            r_out_key    <= w_ld_key;
            r_out_status <= w_ld_status;
            r_out_last   <= w_ld_last;
        end
    end

`ifndef SYNTHESIS
    a_count_matches_slots: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid_vec) == r_count)
        else $error("slot valid bits disagree with entry count");

    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_list_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == psdl_pkg::S_LIST) |-> (r_rem != '0 && r_rem <= r_count))
        else $error("list walk outside the held entries");

    a_valid_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) == w_link[0].valid)
        else $error("head slot validity disagrees with entry count");
`endif

endmodule

`default_nettype wire

>>> sim/tb_priority_sorted_draw_list.sv
`timescale 1ns / 1ps
// self-checking testbench of the priority sorted draw list: directed table, then random traffic

module tb_priority_sorted_draw_list;

    localparam int CAPACITY    = 16;
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 24;
    localparam int RAND_ITEMS  = 334;

    typedef struct packed {
        logic [psdl_pkg::ID_W-1:0]         id;
        logic signed [psdl_pkg::KEY_W-1:0] key;
        psdl_pkg::t_status                 st;
        logic                              last;
    } t_draw_beat;

    typedef struct {
        psdl_pkg::t_mode                   mode;
        logic [psdl_pkg::ID_W-1:0]         id;
        logic signed [psdl_pkg::KEY_W-1:0] key;
        bit                                typed;
        t_draw_beat                        want;
    } t_draw_req;

    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [23:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    logic        m_tready = 1'b0;
    logic        hold_req = 1'b0;
    wire         o_s_tready;
    wire         o_m_tvalid;
    wire  [23:0] o_m_tdata;
    wire  [2:0]  o_m_tuser;
    wire         o_m_tlast;

    // shadow copy of the sorted table
    logic signed [psdl_pkg::KEY_W-1:0] shadow_keys [CAPACITY];
    logic [psdl_pkg::ID_W-1:0]         shadow_ids  [CAPACITY];
    int                                shadow_count = 0;

    t_draw_beat pending_beats [$];
    t_draw_req  req_table [$];
    int         err_cnt      = 0;
    int         tx_gap_pct   = 20;
    int         stall_cycles = 0;

    priority_sorted_draw_list #(
        .CAPACITY (CAPACITY)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_tdata),      // entry_id[7:0], priority_req[23:8]
        .i_s_tuser  (s_tuser),      // mode[1:0]
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (o_m_tdata),    // out_id[7:0], out_priority[23:8]
        .o_m_tuser  (o_m_tuser),    // status[2:0]
        .o_m_tlast  (o_m_tlast)
    );

    always #10 i_clk = ~i_clk;

    function automatic int slot_of(logic [psdl_pkg::ID_W-1:0] id);
        int i;
        for (i = 0; i < shadow_count; i++)
            if (shadow_ids[i] == id)
                return i;
        return shadow_count;
    endfunction

    function automatic void slot_drop(int pos);
        int i;
        for (i = pos; i + 1 < shadow_count; i++) begin
            shadow_keys[i] = shadow_keys[i + 1];
            shadow_ids[i]  = shadow_ids[i + 1];
        end
        shadow_count--;
    endfunction

    // lands in front of the first key that is greater or equal
    function automatic void slot_place(logic [psdl_pkg::ID_W-1:0] id,
                                       logic signed [psdl_pkg::KEY_W-1:0] key);
        int pos;
        int i;
        pos = 0;
        while (pos < shadow_count && key > shadow_keys[pos])
            pos++;
        for (i = shadow_count; i > pos; i--) begin
            shadow_keys[i] = shadow_keys[i - 1];
            shadow_ids[i]  = shadow_ids[i - 1];
        end
        shadow_keys[pos] = key;
        shadow_ids[pos]  = id;
        shadow_count++;
    endfunction

    // applies one request to the shadow table and queues the beats it must produce
    function automatic void predict_draw(psdl_pkg::t_mode mode,
                                         logic [psdl_pkg::ID_W-1:0] id,
                                         logic signed [psdl_pkg::KEY_W-1:0] key);
        int         pos;
        int         i;
        t_draw_beat b;
        pos    = slot_of(id);
        b.id   = id;
        b.key  = '0;
        b.st   = psdl_pkg::ST_OK;
        b.last = 1'b1;
        if (mode == psdl_pkg::MODE_LIST) begin
            if (shadow_count == 0) begin
                b.id = '0;
                b.st = psdl_pkg::ST_EMPTY;
                pending_beats.push_back(b);
            end else begin
                for (i = 0; i < shadow_count; i++) begin
                    b.id   = shadow_ids[i];
                    b.key  = shadow_keys[i];
                    b.last = (i + 1 == shadow_count);
                    pending_beats.push_back(b);
                end
            end
        end else begin
            case (mode)
                psdl_pkg::MODE_INSERT: begin
                    if (pos < shadow_count) begin
                        b.st = psdl_pkg::ST_DUP;
                    end else if (shadow_count >= CAPACITY) begin
                        b.st = psdl_pkg::ST_FULL;
                    end else begin
                        slot_place(id, key);
                        b.key = key;
                    end
                end
                psdl_pkg::MODE_REMOVE: begin
                    if (pos >= shadow_count) begin
                        b.st = psdl_pkg::ST_NOT_FOUND;
                    end else begin
                        b.key = shadow_keys[pos];
                        slot_drop(pos);
                    end
                end
                default: begin
                    if (pos >= shadow_count) begin
                        b.st = psdl_pkg::ST_NOT_FOUND;
                    end else begin
                        if (shadow_keys[pos] != key) begin
                            slot_drop(pos);
                            slot_place(id, key);
                        end
                        b.key = key;
                    end
                end
            endcase
            pending_beats.push_back(b);
        end
    endfunction

    function automatic void add_req(psdl_pkg::t_mode mode, int id, int key);
        t_draw_req r;
        r.mode  = mode;
        r.id    = id[psdl_pkg::ID_W-1:0];
        r.key   = key[psdl_pkg::KEY_W-1:0];
        r.typed = 1'b0;
        r.want  = '0;
        req_table.push_back(r);
    endfunction

    // row whose single result is written out by hand
    function automatic void add_req_want(psdl_pkg::t_mode mode, int id, int key,
                                         int want_id, int want_key,
                                         psdl_pkg::t_status want_st);
        add_req(mode, id, key);
        req_table[req_table.size() - 1].typed     = 1'b1;
        req_table[req_table.size() - 1].want.id   = want_id[psdl_pkg::ID_W-1:0];
        req_table[req_table.size() - 1].want.key  = want_key[psdl_pkg::KEY_W-1:0];
        req_table[req_table.size() - 1].want.st   = want_st;
        req_table[req_table.size() - 1].want.last = 1'b1;
    endfunction

    task automatic send_req(psdl_pkg::t_mode mode, logic [psdl_pkg::ID_W-1:0] id,
                            logic signed [psdl_pkg::KEY_W-1:0] key);
        while ($urandom_range(99) < tx_gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {key, id};
        do
            @(posedge i_clk);
        while (!(s_tvalid && o_s_tready));
        predict_draw(mode, id, key);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_beats.size() != 0)
            @(posedge i_clk);
    endtask

    initial begin : stimulus
        int                         n;
        int                         r;
        psdl_pkg::t_mode            mode;
        logic [psdl_pkg::ID_W-1:0]  id;
        logic [psdl_pkg::KEY_W-1:0] key;
        t_draw_req                  rq;

        add_req_want(psdl_pkg::MODE_LIST,   0,   0,      0,   0,      psdl_pkg::ST_EMPTY);
        add_req_want(psdl_pkg::MODE_REMOVE, 5,   0,      5,   0,      psdl_pkg::ST_NOT_FOUND);
        add_req_want(psdl_pkg::MODE_UPDATE, 5,   123,    5,   0,      psdl_pkg::ST_NOT_FOUND);
        add_req_want(psdl_pkg::MODE_INSERT, 0,   -32768, 0,   -32768, psdl_pkg::ST_OK);
        add_req_want(psdl_pkg::MODE_INSERT, 255, 32767,  255, 32767,  psdl_pkg::ST_OK);
        add_req_want(psdl_pkg::MODE_INSERT, 0,   7,      0,   0,      psdl_pkg::ST_DUP);
        add_req(psdl_pkg::MODE_INSERT, 10, 0);
        add_req(psdl_pkg::MODE_INSERT, 11, 0);        // tie: goes ahead of id 10
        add_req(psdl_pkg::MODE_UPDATE, 10, 0);        // same key, no move
        add_req(psdl_pkg::MODE_UPDATE, 255, -32768);  // moves to the front of the -32768 run
        for (n = 0; n < 12; n++)
            add_req(psdl_pkg::MODE_INSERT, 8'h80 + n * 9, (n % 4) * 3 - 3);
        add_req_want(psdl_pkg::MODE_INSERT, 201, 5, 201, 0, psdl_pkg::ST_FULL);
        add_req_want(psdl_pkg::MODE_INSERT, 11,  9, 11,  0, psdl_pkg::ST_DUP);
        add_req(psdl_pkg::MODE_LIST, 0, 0);
        add_req(psdl_pkg::MODE_REMOVE, 11, 0);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (n = 0; n < req_table.size(); n++) begin
            rq = req_table[n];
            send_req(rq.mode, rq.id, rq.key);
            if (rq.typed)
                pending_beats[pending_beats.size() - 1] = rq.want;
        end
        wait_drained();

        for (n = 0; n < RAND_ITEMS; n++) begin
            if (n == 20)
                hold_req <= 1'b1;
            tx_gap_pct = (n >= 100 && n < 180) ? 0 : 20;
            if (n == 200)
                wait_drained();

            r = $urandom_range(99);
            if (r < 36)
                mode = psdl_pkg::MODE_INSERT;
            else if (r < 60)
                mode = psdl_pkg::MODE_REMOVE;
            else if (r < 88)
                mode = psdl_pkg::MODE_UPDATE;
            else
                mode = psdl_pkg::MODE_LIST;

            // a small id pool keeps hits frequent, the full range now and then
            if ($urandom_range(9) == 0)
                id = psdl_pkg::ID_W'($urandom_range(255));
            else
                id = psdl_pkg::ID_W'($urandom_range(19)) ^ 8'h35;

            r = $urandom_range(99);
            if (r < 35)
                key = psdl_pkg::KEY_W'($urandom_range(8) - 4);
            else if (r < 45)
                key = $urandom_range(1) ? 16'h7fff : 16'h8000;
            else
                key = psdl_pkg::KEY_W'($urandom_range(16'hffff));

            send_req(mode, id, key);
        end
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (err_cnt == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // sink: random back-pressure, one long hold-off, then a steady window
    initial begin : sink
        int hold_left;
        int steady_left;
        bit hold_done;
        hold_left   = 0;
        steady_left = 0;
        hold_done   = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_done) begin
                hold_done   = 1'b1;
                hold_left   = HOLD_CYCLES;
                steady_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (steady_left > 0) begin
                steady_left--;
                m_tready <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(99) >= 20);
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_draw_beat got;
        t_draw_beat want;
        if (i_rst_n && o_m_tvalid && m_tready) begin
            got.id   = o_m_tdata[7:0];
            got.key  = o_m_tdata[23:8];
            got.st   = psdl_pkg::t_status'(o_m_tuser);
            got.last = o_m_tlast;
            if (pending_beats.size() == 0) begin
                err_cnt++;
                $display("%0t: unexpected beat, expected none, got id %0d key %0d st %0d last %0b",
                         $time, got.id, got.key, got.st, got.last);
            end else begin
                want = pending_beats.pop_front();
                if (got.id !== want.id || got.key !== want.key || got.st !== want.st
                        || got.last !== want.last) begin
                    err_cnt++;
                    $display("%0t: beat mismatch, expected id %0d key %0d st %0d last %0b",
                             $time, want.id, want.key, want.st, want.last);
                    $display("%0t:                 got      id %0d key %0d st %0d last %0b",
                             $time, got.id, got.key, got.st, got.last);
                end
            end
        end
    end

    // no beat on either side for too long means the block hung
    always @(posedge i_clk) begin
        if ((s_tvalid && o_s_tready) || (o_m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

endmodule

>>> filelist.f
hdl/psdl_pkg.sv
hdl/psdl_cell.sv
hdl/priority_sorted_draw_list.sv
sim/tb_priority_sorted_draw_list.sv
